/* sv/ppu_pkg.sv */
// Shared types and constants for the particle pool update block.
`timescale 1ns / 1ps
`default_nettype none

package ppu_pkg;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_EMIT_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_POOL_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_SPAWN_LIFE    = 2'd2;
   localparam logic [1:0] CSR_EMIT_ENABLE   = 2'd3;

   // Register reset values
   localparam logic [31:0] EMIT_INTERVAL_RST = 32'd6554;
   localparam logic [6:0]  POOL_LIMIT_RST    = 7'd64;
   localparam logic [31:0] SPAWN_LIFE_RST    = 32'd65536;
   localparam logic        EMIT_ENABLE_RST   = 1'b1;

   // Operations of the shared adder
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_ADD_SAT,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] res;
      logic        carry;    // carry out; for a subtract, set when a >= b
      logic        nonzero;
   } alu_rsp_type;

   // One pool entry as stored in memory
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] life;
   } pool_entry_type;

   // Tick sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_CULL_LIFE,
      ST_CULL_Y,
      ST_ACC,
      ST_SPAWN,
      ST_RPT_START,
      ST_RPT_LOAD,
      ST_RPT_WAIT
   } seq_state_type;

endpackage

`default_nettype wire

/* sv/ppu_alu.sv */
// Shared 32-bit add/subtract unit with carry, saturation and zero flag.
`timescale 1ns / 1ps
`default_nettype none

module ppu_alu
   import ppu_pkg::*;
(
   input  wire alu_req_type req,
   output alu_rsp_type      rsp
);

   logic        is_sub;
   logic [31:0] b_opnd;
   logic [32:0] sum;

   // One adder serves all operations: subtract adds the inverted operand plus one
   always_comb begin
      is_sub = 1'b0;
      case (req.op)
         ALU_ADD:     is_sub = 1'b0;
         ALU_ADD_SAT: is_sub = 1'b0;
         ALU_SUB:     is_sub = 1'b1;
         default:     is_sub = 1'b0;
      endcase
      b_opnd = is_sub ? ~req.b : req.b;
      sum    = {1'b0, req.a} + {1'b0, b_opnd} + {32'd0, is_sub};
   end

   // Saturate on carry out for the accumulator add
   always_comb begin
      rsp.carry = sum[32];
      if (req.op == ALU_ADD_SAT && sum[32]) begin
         rsp.res = '1;
      end else begin
         rsp.res = sum[31:0];
      end
      rsp.nonzero = |sum[31:0];
   end

endmodule

`default_nettype wire

/* sv/ppu_pool_mem.sv */
// Particle pool memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ppu_pool_mem
   import ppu_pkg::*;
#(
   parameter int POOL_DEPTH = 64
) (
   input  wire logic                                            clock,
   input  wire logic                                            wr_en,
   input  wire logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0] wr_addr,
   input  wire pool_entry_type                                  wr_data,
   input  wire logic                                            rd_en,
   input  wire logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0] rd_addr,
   output pool_entry_type                                       rd_data
);

   pool_entry_type mem [POOL_DEPTH];
   pool_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/particle_pool_update.sv */
// Top level of the particle pool update block: registers, tick sequencer and output stage.
//
//  Channel | Direction | Handshake             | Payload
//  req     | in        | req_valid / req_stall | time_step, emitter_x/y/z
//  rsp     | out       | rsp_valid / rsp_stall | pos_x/y/z, life_left, live_count,
//          |           |                       |   valid_res, last
//  csr     | in        | csr_wr_en             | csr_index, csr_wr_data
//
// Each accepted tick item ages every pool entry in a life step and then a y step, runs
// the spawn checks, and then reports each live entry through a load and a wait state;
// the spawn checks are skipped while emission is off, the empty-pool item needs no load
// state, and rsp_stall holds a waiting item in its wait state.
// The single read port of the pool memory and the shared adder set this order: aging an
// entry needs one adder pass for life and one for y, and each report needs one read.
// Reset clears the control state and the pool count; pool contents are left as is
// and are never read before they are written. req_stall is high for the whole tick.
`timescale 1ns / 1ps
`default_nettype none

module particle_pool_update
   import ppu_pkg::*;
#(
   parameter int POOL_DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration port
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wr_data,
   // tick items
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [20:0]        req_time_step,
   input  wire logic signed [31:0] req_emitter_x,
   input  wire logic signed [31:0] req_emitter_y,
   input  wire logic signed [31:0] req_emitter_z,
   // result items
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_pos_z,
   output logic [31:0]             rsp_life_left,
   output logic [6:0]              rsp_live_count,
   output logic                    rsp_valid_res,
   output logic                    rsp_last
);

   localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   // configuration registers
   logic [31:0] emit_interval_ff;
   logic [6:0]  pool_limit_ff;
   logic [31:0] spawn_life_ff;
   logic        emit_enable_ff;

   // sequencer and tick state
   seq_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [31:0]      accum_ff, accum_in;
   logic [20:0]      step_ff, step_in;
   logic [31:0]      ex_ff, ex_in;
   logic [31:0]      ey_ff, ey_in;
   logic [31:0]      ez_ff, ez_in;
   logic [31:0]      life_new_ff, life_new_in;
   logic             keep_ff, keep_in;

   // output stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] pos_x_ff, pos_x_in;
   logic [31:0] pos_y_ff, pos_y_in;
   logic [31:0] pos_z_ff, pos_z_in;
   logic [31:0] life_left_ff, life_left_in;
   logic [6:0]  live_count_ff, live_count_in;
   logic        valid_res_ff, valid_res_in;
   logic        last_ff, last_in;

   // memory and adder hookup
   logic           mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   pool_entry_type mem_wr_data;
   logic           mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   pool_entry_type mem_rd_data;
   alu_req_type    alu_req;
   alu_rsp_type    alu_rsp;

   // derived conditions
   logic [CNT_W-1:0] next_idx;
   logic [CMP_W-1:0] lim_eff;
   logic [CMP_W-1:0] cnt_cmp;
   logic [31:0]      step_ext;
   logic             cnt_zero;
   logic             cull_more;
   logic             spawn_ok;
   logic             req_accept;

   ppu_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   ppu_pool_mem #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_interval_ff <= EMIT_INTERVAL_RST;
         pool_limit_ff    <= POOL_LIMIT_RST;
         spawn_life_ff    <= SPAWN_LIFE_RST;
         emit_enable_ff   <= EMIT_ENABLE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EMIT_INTERVAL: emit_interval_ff <= csr_wr_data;
            CSR_POOL_LIMIT:    pool_limit_ff    <= csr_wr_data[6:0];
            CSR_SPAWN_LIFE:    spawn_life_ff    <= csr_wr_data;
            CSR_EMIT_ENABLE:   emit_enable_ff   <= csr_wr_data[0];
            default:           emit_enable_ff   <= emit_enable_ff;
         endcase
      end
   end

   // Shared conditions
   always_comb begin
      next_idx   = rd_idx_ff + 1'b1;
      cnt_cmp    = CMP_W'(cnt_ff);
      lim_eff    = (CMP_W'(pool_limit_ff) > CMP_W'(POOL_DEPTH)) ?
                   CMP_W'(POOL_DEPTH) : CMP_W'(pool_limit_ff);
      step_ext   = 32'(step_ff);
      cnt_zero   = (cnt_ff == '0);
      cull_more  = (next_idx < cnt_ff);
      spawn_ok   = alu_rsp.carry && (cnt_cmp < lim_eff);
      req_accept = req_valid && !req_stall;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_accept) state_in = ST_START;
         ST_START:     state_in = cnt_zero ? ST_ACC : ST_CULL_LIFE;
         ST_CULL_LIFE: state_in = ST_CULL_Y;
         ST_CULL_Y:    state_in = cull_more ? ST_CULL_LIFE : ST_ACC;
         ST_ACC:       state_in = emit_enable_ff ? ST_SPAWN : ST_RPT_START;
         ST_SPAWN:     state_in = spawn_ok ? ST_SPAWN : ST_RPT_START;
         ST_RPT_START: state_in = cnt_zero ? ST_RPT_WAIT : ST_RPT_LOAD;
         ST_RPT_LOAD:  state_in = ST_RPT_WAIT;
         ST_RPT_WAIT: begin
            if (!rsp_stall) begin
               state_in = last_ff ? ST_IDLE : ST_RPT_LOAD;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath control and register updates
   always_comb begin
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      kept_in       = kept_ff;
      accum_in      = accum_ff;
      step_in       = step_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      ez_in         = ez_ff;
      life_new_in   = life_new_ff;
      keep_in       = keep_ff;
      rsp_valid_in  = rsp_valid_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      pos_z_in      = pos_z_ff;
      life_left_in  = life_left_ff;
      live_count_in = live_count_ff;
      valid_res_in  = valid_res_ff;
      last_in       = last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = kept_ff[IDX_W-1:0];
      mem_wr_data   = '{x: mem_rd_data.x, y: alu_rsp.res, z: mem_rd_data.z,
                        life: life_new_ff};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_idx_ff[IDX_W-1:0];
      alu_req       = '{op: ALU_ADD, a: mem_rd_data.y, b: step_ext};

      case (state_ff)
         // latch the tick item
         ST_IDLE: begin
            if (req_accept) begin
               step_in   = req_time_step;
               ex_in     = req_emitter_x;
               ey_in     = req_emitter_y;
               ez_in     = req_emitter_z;
               rd_idx_in = '0;
               kept_in   = '0;
            end
         end
         // fetch the first entry
         ST_START: begin
            mem_rd_en   = !cnt_zero;
            mem_rd_addr = '0;
         end
         // age: life minus step, keep if it stays above zero
         ST_CULL_LIFE: begin
            alu_req     = '{op: ALU_SUB, a: mem_rd_data.life, b: step_ext};
            life_new_in = alu_rsp.res;
            keep_in     = alu_rsp.carry && alu_rsp.nonzero;
         end
         // move up, compact survivor, fetch the next entry
         ST_CULL_Y: begin
            alu_req     = '{op: ALU_ADD, a: mem_rd_data.y, b: step_ext};
            mem_wr_en   = keep_ff;
            kept_in     = kept_ff + CNT_W'(keep_ff);
            rd_idx_in   = next_idx;
            mem_rd_en   = cull_more;
            mem_rd_addr = next_idx[IDX_W-1:0];
            if (!cull_more) begin
               cnt_in = kept_ff + CNT_W'(keep_ff);
            end
         end
         // grow the accumulator
         ST_ACC: begin
            alu_req = '{op: ALU_ADD_SAT, a: accum_ff, b: step_ext};
            if (emit_enable_ff) begin
               accum_in = alu_rsp.res;
            end
         end
         // spawn one particle per interval while below the limit
         ST_SPAWN: begin
            alu_req     = '{op: ALU_SUB, a: accum_ff, b: emit_interval_ff};
            mem_wr_addr = cnt_ff[IDX_W-1:0];
            mem_wr_data = '{x: ex_ff, y: ey_ff, z: ez_ff, life: spawn_life_ff};
            if (spawn_ok) begin
               mem_wr_en = 1'b1;
               accum_in  = alu_rsp.res;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         // start the report, or give the empty-pool item
         ST_RPT_START: begin
            rd_idx_in   = '0;
            mem_rd_en   = !cnt_zero;
            mem_rd_addr = '0;
            if (cnt_zero) begin
               rsp_valid_in  = 1'b1;
               pos_x_in      = '0;
               pos_y_in      = '0;
               pos_z_in      = '0;
               life_left_in  = '0;
               live_count_in = '0;
               valid_res_in  = 1'b0;
               last_in       = 1'b1;
            end
         end
         // load one particle into the output stage
         ST_RPT_LOAD: begin
            rsp_valid_in  = 1'b1;
            pos_x_in      = mem_rd_data.x;
            pos_y_in      = mem_rd_data.y;
            pos_z_in      = mem_rd_data.z;
            life_left_in  = mem_rd_data.life;
            live_count_in = cnt_cmp[6:0];
            valid_res_in  = 1'b1;
            last_in       = (next_idx == cnt_ff);
         end
         // hold until taken, then fetch the next particle
         ST_RPT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (!last_ff) begin
                  rd_idx_in   = next_idx;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = next_idx[IDX_W-1:0];
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         kept_ff      <= '0;
         accum_ff     <= '0;
         keep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         kept_ff      <= kept_in;
         accum_ff     <= accum_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      ex_ff         <= ex_in;
      ey_ff         <= ey_in;
      ez_ff         <= ez_in;
      life_new_ff   <= life_new_in;
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      pos_z_ff      <= pos_z_in;
      life_left_ff  <= life_left_in;
      live_count_ff <= live_count_in;
      valid_res_ff  <= valid_res_in;
      last_ff       <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_pos_z      = pos_z_ff;
   assign rsp_life_left  = life_left_ff;
   assign rsp_live_count = live_count_ff;
   assign rsp_valid_res  = valid_res_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire
